@@ hw/rtl/fta_pkg.sv @@
// shared types and constants for the truncating single-precision adder
package fta_pkg;

   localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
   localparam logic [22:0] QNAN_FRAC    = 23'h400000;
   localparam logic [31:0] DEFAULT_NAN  = 32'h7FC00000;

   typedef struct packed {
      logic        special;
      logic [31:0] special_word;
      logic        sign_big;
      logic        sign_lesser;
      logic [7:0]  exp;
      logic [7:0]  diff;
      logic [23:0] big;
      logic [23:0] lesser;
   } align_type;

   typedef struct packed {
      logic        special;
      logic [31:0] special_word;
      logic        sign;
      logic [7:0]  exp;
      logic [24:0] mant;
   } norm_type;

endpackage

@@ hw/rtl/fta_stream_if.sv @@
// valid/ready channel carrying one payload word
interface fta_stream_if #(
   parameter int Width = 32
);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fta_normalise.sv @@
// leading-zero count and normalising shift of the raw sum, with carry shift, overflow and special pass-through
module fta_normalise (
   input  fta_pkg::norm_type n,
   output logic [31:0]       word
);
   logic [4:0]  lz;
   logic [7:0]  e;
   logic [24:0] m;
   logic [7:0]  sh;

   always_comb begin
      lz = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (n.mant[i]) begin
            lz = 5'(23 - i);
         end
      end
      e = n.exp;
      m = n.mant;
      sh = '0;
      word = '0;
      if (n.special) begin
         word = n.special_word;
      end else if (n.mant == '0) begin
         word = '0;
      end else if (n.mant[24]) begin
         m = n.mant >> 1;
         e = n.exp + 8'd1;
         if (e == fta_pkg::EXP_ALL_ONES) begin
            word = {n.sign, fta_pkg::EXP_ALL_ONES, 23'd0};
         end else begin
            word = {n.sign, e, m[22:0]};
         end
      end else begin
         if (!n.mant[23]) begin
            if (n.exp > {3'd0, lz}) begin
               sh = {3'd0, lz};
               e = n.exp - sh;
            end else begin
               sh = n.exp - 8'd1;
               e = 8'd1;
            end
            m = n.mant << sh[4:0];
         end
         if (!m[23]) begin
            e = '0;
         end
         word = {n.sign, e, m[22:0]};
      end
   end
endmodule

@@ hw/rtl/float32_truncating_adder.sv @@
// top level of the pipelined truncating single-precision adder
//  channel  | dir | fields
//  req      | in  | operand_a[31:0], operand_b[31:0]
//  rsp      | out | sum_bits[31:0]
// four register stages: unpack/compare, align shift, add, normalise
// one word accepted per cycle while req.ready is high, result registered through s1_ff, s2_ff, s3_ff and s4_ff in turn
// synchronous active-high reset clears the valid bits only
// a stall on rsp holds each full stage with no bubble after it; a bubble stage still takes new words
module float32_truncating_adder (
   input logic clock,
   input logic reset,
   fta_stream_if.sink   req,
   fta_stream_if.source rsp
);
   logic [3:0] vld_ff, vld_in;
   logic [3:0] adv;
   fta_pkg::align_type s1_ff, s1_in, s2_ff, s2_in;
   fta_pkg::norm_type  s3_ff, s3_in;
   logic [31:0] s4_ff, s4_in;

   assign adv[3] = !vld_ff[3] || rsp.ready;
   assign adv[2] = !vld_ff[2] || adv[3];
   assign adv[1] = !vld_ff[1] || adv[2];
   assign adv[0] = !vld_ff[0] || adv[1];
   assign req.ready = adv[0];
   assign rsp.valid = vld_ff[3];
   assign rsp.data  = s4_ff;

   always_comb begin
      vld_in[0] = adv[0] ? req.valid : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = adv[3] ? vld_ff[2] : vld_ff[3];
   end

   // stage 1: unpack, specials, compare exponents
   logic [31:0] a, b;
   logic        sa, sb;
   logic [7:0]  ea, eb, ka, kb;
   logic [22:0] fa, fb;
   logic [23:0] ma, mb;
   assign a = req.data[31:0];
   assign b = req.data[63:32];
   always_comb begin
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0]; fb = b[22:0];
      ma = {ea != 8'd0, fa};
      mb = {eb != 8'd0, fb};
      ka = (ea != 8'd0) ? ea : 8'd1;
      kb = (eb != 8'd0) ? eb : 8'd1;
      s1_in = '0;
      s1_in.special = 1'b1;
      if ((ea == fta_pkg::EXP_ALL_ONES && fa != '0) ||
          (eb == fta_pkg::EXP_ALL_ONES && fb != '0)) begin
         s1_in.special_word = fta_pkg::DEFAULT_NAN;
      end else if (ea == fta_pkg::EXP_ALL_ONES && eb == fta_pkg::EXP_ALL_ONES
                   && sa != sb) begin
         s1_in.special_word = {1'b0, fta_pkg::EXP_ALL_ONES, fta_pkg::QNAN_FRAC};
      end else if (ea == fta_pkg::EXP_ALL_ONES) begin
         s1_in.special_word = {sa, fta_pkg::EXP_ALL_ONES, 23'd0};
      end else if (eb == fta_pkg::EXP_ALL_ONES) begin
         s1_in.special_word = {sb, fta_pkg::EXP_ALL_ONES, 23'd0};
      end else if (a[30:0] == '0) begin
         s1_in.special_word = (b[30:0] == '0) ? 32'd0 : b;
      end else if (b[30:0] == '0) begin
         s1_in.special_word = a;
      end else begin
         s1_in.special = 1'b0;
      end
      if (ka >= kb) begin
         s1_in.exp = ka; s1_in.diff = ka - kb;
         s1_in.big = ma; s1_in.lesser = mb;
         s1_in.sign_big = sa; s1_in.sign_lesser = sb;
      end else begin
         s1_in.exp = kb; s1_in.diff = kb - ka;
         s1_in.big = mb; s1_in.lesser = ma;
         s1_in.sign_big = sb; s1_in.sign_lesser = sa;
      end
   end

   // stage 2: align
   always_comb begin
      s2_in = s1_ff;
      s2_in.lesser = (s1_ff.diff >= 8'd24) ? 24'd0 : (s1_ff.lesser >> s1_ff.diff[4:0]);
   end

   // stage 3: signed-magnitude add
   always_comb begin
      s3_in.special = s2_ff.special;
      s3_in.special_word = s2_ff.special_word;
      s3_in.exp = s2_ff.exp;
      if (s2_ff.sign_big == s2_ff.sign_lesser) begin
         s3_in.mant = {1'b0, s2_ff.big} + {1'b0, s2_ff.lesser};
         s3_in.sign = s2_ff.sign_big;
      end else if (s2_ff.big >= s2_ff.lesser) begin
         s3_in.mant = {1'b0, s2_ff.big - s2_ff.lesser};
         s3_in.sign = s2_ff.sign_big;
      end else begin
         s3_in.mant = {1'b0, s2_ff.lesser - s2_ff.big};
         s3_in.sign = s2_ff.sign_lesser;
      end
   end

   // stage 4: normalise
   fta_normalise u_norm (.n(s3_ff), .word(s4_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      if (adv[0]) s1_ff <= s1_in;
      if (adv[1]) s2_ff <= s2_in;
      if (adv[2]) s3_ff <= s3_in;
      if (adv[3]) s4_ff <= s4_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("stalled result changed");
   a_nan: assert property (@(posedge clock) disable iff (reset)
      adv[3] && vld_ff[2] && s3_ff.special |=> rsp.data == $past(s3_ff.special_word))
      else $error("special word lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> req.ready)
      else $error("empty pipe refused word");
endmodule
